// ===== rtl/core/pip_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pip_pkg;

	// Vertex table geometry
	localparam int MAX_VERTICES = 16;
	localparam int VTX_AW       = $clog2(MAX_VERTICES);
	localparam int COORD_W      = 16;
	localparam int CNT_W        = 5;
	localparam int VTX_W        = 2 * COORD_W;
	localparam int DIFF_W       = COORD_W + 1;
	localparam int PROD_W       = 2 * DIFF_W;

	// Request type codes
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_TEST = 1'b1;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRIME,
		ST_WALK,
		ST_DRAIN,
		ST_FINISH
	} pip_state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic              wr_en;
		logic              load_pt;
		logic              load_prev;
		logic              edge_en;
		logic              emit;
		logic [VTX_AW-1:0] rd_addr;
	} pip_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic out_free;
	} pip_sts_t;

endpackage

`default_nettype wire

// ===== rtl/core/pip_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pip_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one entry, read one entry into the output register
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/core/pip_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pip_dp
	import pip_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire pip_cmd_t                  cmd,
	output pip_sts_t                       sts,
	input  wire logic [VTX_AW-1:0]         vertex_slot,
	input  wire logic signed [COORD_W-1:0] coord_x,
	input  wire logic signed [COORD_W-1:0] coord_y,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic                           inside_res
);

	logic [VTX_W-1:0]          rdata;
	logic signed [COORD_W-1:0] px_q, py_q;
	logic signed [COORD_W-1:0] prev_x_q, prev_y_q;
	logic signed [COORD_W-1:0] cur_x, cur_y;
	logic signed [DIFF_W-1:0]  xi_e, yi_e, xj_e, yj_e, px_e, py_e;
	logic signed [DIFF_W-1:0]  dy, ax, bx, cy;
	logic signed [PROD_W-1:0]  lhs, rhs;
	logic signed [PROD_W-1:0]  lhs_s1, rhs_s1;
	logic                      strad_s1, dypos_s1, valid_s1;
	logic                      straddle, flip;
	logic                      flag_q;
	logic                      out_valid_q, inside_q;

	// Vertex table, x in the upper half
	pip_ram #(
		.WIDTH(VTX_W),
		.DEPTH(MAX_VERTICES)
	) u_vtx_ram (
		.clk  (clk),
		.we   (cmd.wr_en),
		.waddr(vertex_slot),
		.wdata({coord_x, coord_y}),
		.raddr(cmd.rd_addr),
		.rdata(rdata)
	);

	assign cur_x = rdata[VTX_W-1:COORD_W];
	assign cur_y = rdata[COORD_W-1:0];

	// Latch the test point, hold the previous vertex
	always_ff @(posedge clk) begin
		if (cmd.load_pt) begin
			px_q <= coord_x;
			py_q <= coord_y;
		end
		if (cmd.load_prev || cmd.edge_en) begin
			prev_x_q <= cur_x;
			prev_y_q <= cur_y;
		end
	end

	// Edge stage one: straddle test and cross products
	assign xi_e = {cur_x[COORD_W-1], cur_x};
	assign yi_e = {cur_y[COORD_W-1], cur_y};
	assign xj_e = {prev_x_q[COORD_W-1], prev_x_q};
	assign yj_e = {prev_y_q[COORD_W-1], prev_y_q};
	assign px_e = {px_q[COORD_W-1], px_q};
	assign py_e = {py_q[COORD_W-1], py_q};

	assign straddle = (cur_y > py_q) != (prev_y_q > py_q);
	assign dy  = yj_e - yi_e;
	assign ax  = px_e - xi_e;
	assign bx  = xj_e - xi_e;
	assign cy  = py_e - yi_e;
	assign lhs = ax * dy;
	assign rhs = bx * cy;

	always_ff @(posedge clk) begin
		lhs_s1   <= lhs;
		rhs_s1   <= rhs;
		strad_s1 <= straddle;
		dypos_s1 <= ~dy[DIFF_W-1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.edge_en;
		end
	end

	// Edge stage two: sign-corrected compare, toggle the flag
	assign flip = valid_s1 && strad_s1 &&
		(dypos_s1 ? (lhs_s1 < rhs_s1) : (lhs_s1 > rhs_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flag_q <= 1'b0;
		end else if (cmd.load_pt) begin
			flag_q <= 1'b0;
		end else if (flip) begin
			flag_q <= ~flag_q;
		end
	end

	// Output register: hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			inside_q <= flag_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign inside_res   = inside_q;
	assign sts.out_free = !out_valid_q || !out_stall;

	// A new result never overwrites one that is still stalled
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !(out_valid_q && out_stall))
		else $error("result overwritten while stalled");

	// Edge stage one only fills from walk steps
	a_valid_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> !cmd.load_pt && !cmd.emit)
		else $error("edge pipeline busy at request start or result");

	// A stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stall |=> out_valid_q && $stable(inside_q))
		else $error("stalled result changed");

endmodule

`default_nettype wire

// ===== rtl/core/pip_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pip_ctrl
	import pip_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_wen,
	input  wire logic [CNT_W-1:0] cfg_wdata,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic             req_type,
	output pip_cmd_t              cmd,
	input  wire pip_sts_t         sts
);

	pip_state_t        state_q, state_d;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  n_sat;
	logic [VTX_AW-1:0] last_q, last_d;
	logic [VTX_AW-1:0] idx_q, idx_d;
	logic              accept;

	// Vertex count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cfg_wen) begin
			count_q <= cfg_wdata;
		end
	end

	// Clamp the count to the table depth
	assign n_sat = (count_q > CNT_W'(MAX_VERTICES)) ? CNT_W'(MAX_VERTICES) : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			last_q  <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			last_q  <= last_d;
			idx_q   <= idx_d;
		end
	end

	assign accept = in_valid && !in_stall;

	// Next state and commands
	always_comb begin
		state_d       = state_q;
		last_d        = last_q;
		idx_d         = idx_q;
		in_stall      = 1'b1;
		cmd.wr_en     = 1'b0;
		cmd.load_pt   = 1'b0;
		cmd.load_prev = 1'b0;
		cmd.edge_en   = 1'b0;
		cmd.emit      = 1'b0;
		cmd.rd_addr   = '0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid && req_type == REQ_LOAD) begin
					cmd.wr_en = 1'b1;
				end else if (in_valid && req_type == REQ_TEST) begin
					cmd.load_pt = 1'b1;
					last_d      = VTX_AW'(n_sat - CNT_W'(1));
					cmd.rd_addr = VTX_AW'(n_sat - CNT_W'(1));
					if (n_sat < CNT_W'(3)) begin
						state_d = ST_FINISH;
					end else begin
						state_d = ST_PRIME;
					end
				end
			end
			ST_PRIME: begin
				// Closing vertex arrives; fetch vertex zero
				cmd.load_prev = 1'b1;
				cmd.rd_addr   = '0;
				idx_d         = '0;
				state_d       = ST_WALK;
			end
			ST_WALK: begin
				// One edge per cycle
				cmd.edge_en = 1'b1;
				cmd.rd_addr = idx_q + VTX_AW'(1);
				idx_d       = idx_q + VTX_AW'(1);
				if (idx_q == last_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// A test request always leaves idle
	a_test_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req_type == REQ_TEST |=> state_q != ST_IDLE)
		else $error("test request not started");

	// Walk index never passes the last vertex
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WALK |-> idx_q <= last_q)
		else $error("walk index beyond last vertex");

	// Result delivery returns to idle
	a_emit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> state_q == ST_IDLE)
		else $error("no return to idle after result");

	// Loads never write during a walk
	a_wr_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> state_q == ST_IDLE && accept)
		else $error("vertex write outside idle");

endmodule

`default_nettype wire

// ===== rtl/core/point_in_polygon_test.sv =====
// Sequence: an accepted test request with n vertices in use (n clamped to 16) passes
//   prime, one walk step per edge, drain and finish; with n below 3 it goes to finish.
// Flow: the result is registered once the output is free, and only then is a new request
//   taken; one edge per cycle through the single read port of the vertex table.
// Reset: arst_n clears the vertex count, controller and output valid at once;
//   the vertex table is not cleared and holds garbage until loaded.
`timescale 1ns / 1ps
`default_nettype none

module point_in_polygon_test
	import pip_pkg::*;
(
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_wen,
	input  wire logic [CNT_W-1:0]          cfg_wdata,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic                      req_type,
	input  wire logic [VTX_AW-1:0]         vertex_slot,
	input  wire logic signed [COORD_W-1:0] coord_x,
	input  wire logic signed [COORD_W-1:0] coord_y,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic                           inside_res
);

	pip_cmd_t cmd;
	pip_sts_t sts;

	// Sequencer
	pip_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.req_type (req_type),
		.cmd      (cmd),
		.sts      (sts)
	);

	// Vertex table, edge arithmetic and result register
	pip_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.vertex_slot(vertex_slot),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.inside_res (inside_res)
	);

endmodule

`default_nettype wire

// ===== sim/point_in_polygon_test_tb.sv =====
`timescale 1ns / 1ps

module point_in_polygon_test_tb;
	import pip_pkg::*;

	localparam int DRAIN_CYCLES = 25;
	localparam int QUIET_LIMIT  = 4000;
	localparam int MODE_ITEMS   = 380;

	typedef struct {
		logic                      rt;
		logic [VTX_AW-1:0]         slot;
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} poly_req_t;

	logic                      clk;
	logic                      arst_n      = 1'b0;
	logic                      cfg_wen     = 1'b0;
	logic [CNT_W-1:0]          cfg_wdata   = '0;
	logic                      in_valid    = 1'b0;
	logic                      in_stall;
	logic                      req_type    = REQ_LOAD;
	logic [VTX_AW-1:0]         vertex_slot = '0;
	logic signed [COORD_W-1:0] coord_x     = '0;
	logic signed [COORD_W-1:0] coord_y     = '0;
	logic                      out_valid;
	logic                      out_stall   = 1'b0;
	logic                      inside_res;

	// Requests waiting to be driven, and inside flags waiting to come back
	poly_req_t pending[$];
	bit        inside_queue[$];
	poly_req_t next_req;

	// Predictor copy of the vertex table and the count
	logic signed [COORD_W-1:0] poly_x [MAX_VERTICES];
	logic signed [COORD_W-1:0] poly_y [MAX_VERTICES];
	logic [CNT_W-1:0]          vtx_count = '0;

	// Generator view of the table, kept at generation time
	int               gen_x [MAX_VERTICES];
	int               gen_y [MAX_VERTICES];
	bit [MAX_VERTICES-1:0] loaded_slots = '0;

	int send_gap_pct   = 0;
	int recv_stall_pct = 0;
	int mode_items     = 0;
	int quiet_cycles   = 0;
	int n_errors       = 0;
	int n_loads        = 0;
	int n_tests        = 0;
	int n_inside       = 0;
	int n_cfg_writes   = 0;

	point_in_polygon_test dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wen     (cfg_wen),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.vertex_slot (vertex_slot),
		.coord_x     (coord_x),
		.coord_y     (coord_y),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.inside_res  (inside_res)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Even-odd crossing test over the stored polygon, exact integer compare
	function automatic bit point_is_inside(logic signed [COORD_W-1:0] px,
			logic signed [COORD_W-1:0] py);
		logic signed [DIFF_W-1:0] dy, dxp, dxe, dyp;
		logic signed [PROD_W-1:0] lhs, rhs;
		int n, i, j;
		bit in_poly;
		n = (vtx_count > MAX_VERTICES) ? MAX_VERTICES : vtx_count;
		in_poly = 1'b0;
		if (n >= 3) begin
			j = n - 1;
			for (i = 0; i < n; i++) begin
				// flip only when the edge straddles py and the point is left of it
				if ((poly_y[i] > py) != (poly_y[j] > py)) begin
					dy  = poly_y[j] - poly_y[i];
					dxp = px - poly_x[i];
					dxe = poly_x[j] - poly_x[i];
					dyp = py - poly_y[i];
					lhs = dxp * dy;
					rhs = dxe * dyp;
					if (dy > 0 ? (lhs < rhs) : (lhs > rhs))
						in_poly = !in_poly;
				end
				j = i;
			end
		end
		return in_poly;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("ERROR @%0t: %s", $time, msg);
		n_errors++;
	endtask

	function automatic int clamp16(int v);
		if (v > 32767)
			return 32767;
		if (v < -32768)
			return -32768;
		return v;
	endfunction

	function automatic int rand_around(int c, int span);
		int off;
		off = int'($urandom_range(2 * span)) - span;
		return clamp16(c + off);
	endfunction

	function automatic void queue_load(int slot, int x, int y);
		poly_req_t r;
		r.rt   = REQ_LOAD;
		r.slot = slot[VTX_AW-1:0];
		r.x    = x[COORD_W-1:0];
		r.y    = y[COORD_W-1:0];
		pending.push_back(r);
		gen_x[slot] = x;
		gen_y[slot] = y;
		loaded_slots[slot] = 1'b1;
		mode_items++;
	endfunction

	function automatic void queue_test(int x, int y);
		poly_req_t r;
		r.rt   = REQ_TEST;
		r.slot = VTX_AW'($urandom_range(MAX_VERTICES - 1));
		r.x    = x[COORD_W-1:0];
		r.y    = y[COORD_W-1:0];
		pending.push_back(r);
		mode_items++;
	endfunction

	// Block until every request is in and every result is out, then let the block settle
	task automatic wait_quiet();
		do @(negedge clk); while (pending.size() != 0 || in_valid || inside_queue.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_vertex_count(input int value);
		@(posedge clk);
		cfg_wen   <= 1'b1;
		cfg_wdata <= value[CNT_W-1:0];
		vtx_count = value[CNT_W-1:0];
		n_cfg_writes++;
		@(posedge clk);
		cfg_wen <= 1'b0;
	endtask

	// Drive requests; predict at the edge where each one is taken
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				if (req_type == REQ_LOAD) begin
					poly_x[vertex_slot] = coord_x;
					poly_y[vertex_slot] = coord_y;
					n_loads++;
				end else begin
					inside_queue.push_back(point_is_inside(coord_x, coord_y));
					n_tests++;
				end
			end
			// advance only when the current request is gone
			if (!in_valid || !in_stall) begin
				if (pending.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					next_req = pending.pop_front();
					in_valid    <= 1'b1;
					req_type    <= next_req.rt;
					vertex_slot <= next_req.slot;
					coord_x     <= next_req.x;
					coord_y     <= next_req.y;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Check each taken result against the oldest prediction
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (inside_queue.size() == 0) begin
					report_mismatch("result with no test request pending");
				end else begin
					if (inside_res !== inside_queue[0])
						report_mismatch($sformatf("inside_res got %b want %b",
							inside_res, inside_queue[0]));
					if (inside_queue[0])
						n_inside++;
					void'(inside_queue.pop_front());
				end
			end
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Count cycles with no handshake on either side
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wen)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(posedge clk);
		$display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
		$display("FAIL");
		$finish;
	end

	initial begin
		int forced_counts [8];
		int mode, seg, c, n, k, t, i, idx, tmp, span, cx, cy, x, y;
		int order [MAX_VERTICES];
		bit reload;
		forced_counts = '{16, 31, 3, 0, 17, 1, 2, 15};
		seg = 0;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		send_gap_pct   = 27;
		recv_stall_pct = 81;
		repeat (2) @(posedge clk);

		// Directed: empty count, extreme square, edges and corners, short counts
		write_vertex_count(0);
		queue_test(-32768, 32767);
		queue_load(0, -32768, -32768);
		queue_load(1, 32767, -32768);
		queue_load(2, 32767, 32767);
		queue_load(3, -32768, 32767);
		wait_quiet();
		write_vertex_count(4);
		queue_test(0, 0);
		queue_test(-32768, -32768);
		queue_test(32767, 0);
		queue_test(-32768, 0);
		queue_test(0, 32767);
		queue_test(0, -32768);
		queue_test(32767, 32767);
		queue_test(-32767, -32767);
		wait_quiet();
		write_vertex_count(2);
		queue_test(0, 0);
		wait_quiet();
		write_vertex_count(3);
		queue_test(16384, -16384);
		queue_test(-16384, 16384);
		queue_test(0, 0);
		wait_quiet();

		// Random: polygons of random size and scale, then points around them
		for (mode = 0; mode < 3; mode++) begin
			case (mode)
				0: begin send_gap_pct = 27; recv_stall_pct = 81; end
				1: begin send_gap_pct = 81; recv_stall_pct = 27; end
				default: begin send_gap_pct = 0; recv_stall_pct = 0; end
			endcase
			mode_items = 0;
			while (mode_items < MODE_ITEMS) begin
				if (seg < 8)
					c = forced_counts[seg];
				else if ($urandom_range(4) != 0)
					c = $urandom_range(3, MAX_VERTICES);
				else
					c = $urandom_range((1 << CNT_W) - 1);
				seg++;
				n = (c > MAX_VERTICES) ? MAX_VERTICES : c;
				write_vertex_count(c);

				case ($urandom_range(2))
					0: span = $urandom_range(2, 40);
					1: span = $urandom_range(100, 3000);
					default: span = 32768;
				endcase
				cx = (span == 32768) ? 0 : rand_around(0, 32768);
				cy = (span == 32768) ? 0 : rand_around(0, 32768);

				// reload the polygon if a slot in use holds no vertex yet, else in three of four cases
				reload = 1'b0;
				for (i = 0; i < n; i++)
					if (!loaded_slots[i])
						reload = 1'b1;
				if (reload || $urandom_range(3) != 0) begin
					for (i = 0; i < n; i++)
						order[i] = i;
					for (i = n - 1; i > 0; i--) begin
						idx = $urandom_range(i);
						tmp = order[i];
						order[i] = order[idx];
						order[idx] = tmp;
					end
					for (i = 0; i < n; i++)
						queue_load(order[i], rand_around(cx, span), rand_around(cy, span));
				end

				k = $urandom_range(8, 30);
				for (t = 0; t < k; t++) begin
					// drop in a stray vertex load now and then
					if ($urandom_range(11) == 0) begin
						idx = $urandom_range(MAX_VERTICES - 1);
						queue_load(idx, rand_around(cx, span), rand_around(cy, span));
					end
					idx = (n > 0) ? $urandom_range(n - 1) : 0;
					case ($urandom_range(19))
						0, 1, 2: begin
							x = (n > 0) ? gen_x[idx] : rand_around(0, 32768);
							y = (n > 0) ? gen_y[idx] : rand_around(0, 32768);
						end
						3, 4: begin
							x = rand_around(cx, span);
							y = (n > 0) ? gen_y[idx] : rand_around(cy, span);
						end
						5, 6, 7: begin
							x = rand_around(0, 32768);
							y = rand_around(0, 32768);
						end
						default: begin
							x = rand_around(cx, span);
							y = rand_around(cy, span);
						end
					endcase
					queue_test(x, y);
				end
				wait_quiet();
			end
		end

		wait_quiet();
		if (inside_queue.size() != 0)
			report_mismatch($sformatf("%0d test results never arrived", inside_queue.size()));
		$display("Run covered %0d vertex loads and %0d point tests (%0d inside)",
			n_loads, n_tests, n_inside);
		$display("across %0d vertex_count writes, %0d mismatches", n_cfg_writes, n_errors);
		if (n_errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
